[hdl/keda_pkg.sv]
// Shared types, widths and the operation schedule for the kinetic energy
// density accumulator. Used by keda_ctrl, keda_dpath and the top level.
// No dependencies.
package keda_pkg;

    // Field widths, signed Q.FRAC_W fixed point
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 20;
    localparam int ACC_W    = 48;
    localparam int OCC_W    = 22;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier operand: square of a sample after the shift plus
    // headroom for sums of three squares and for differences
    localparam int MUL_W  = 2 * SAMPLE_W - FRAC_W + 1;
    localparam int P_W    = 2 * MUL_W;
    localparam int GSUM_W = MUL_W + 2;
    localparam int TERM_W = 2 * MUL_W - FRAC_W + 2;
    // term * occupancy is split into a low unsigned and a high signed slice
    localparam int LO_W   = TERM_W - MUL_W;
    localparam int WP_W   = TERM_W + OCC_W + 1;
    localparam int STEP_W = 5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_X          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_Y          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K_Z          = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_GXR, OP_GYR, OP_GZR,
        OP_GXI, OP_GYI, OP_GZI,
        OP_FIN,
        OP_KX, OP_KY, OP_KZ,
        OP_PR, OP_PI,
        OP_CX1, OP_CX2, OP_CY1, OP_CY2, OP_CZ1, OP_CZ2,
        OP_KP, OP_KCX, OP_KCY, OP_KCZ,
        OP_OLO, OP_OHI,
        OP_ACC
    } keda_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } keda_state_t;

    typedef struct packed {
        logic     load;
        keda_op_t op;
    } keda_cmd_t;

    typedef struct packed {
        logic complex_mode;
        logic last_vector;
        logic out_full;
    } keda_stat_t;

    // One operation issued per cycle unless the final step is held on a
    // full output register; NOP slots cover a write-back dependency.
    function automatic keda_op_t sched_op(input logic cmode,
                                          input logic [STEP_W-1:0] step);
        keda_op_t op;
        op = OP_NOP;
        if (cmode)
        begin
            case (step)
                5'd0:    op = OP_GXR;
                5'd1:    op = OP_GYR;
                5'd2:    op = OP_GZR;
                5'd3:    op = OP_GXI;
                5'd4:    op = OP_GYI;
                5'd5:    op = OP_GZI;
                5'd6:    op = OP_FIN;
                5'd7:    op = OP_KX;
                5'd8:    op = OP_KY;
                5'd9:    op = OP_KZ;
                5'd10:   op = OP_PR;
                5'd11:   op = OP_PI;
                5'd12:   op = OP_CX1;
                5'd13:   op = OP_CX2;
                5'd14:   op = OP_CY1;
                5'd15:   op = OP_CY2;
                5'd16:   op = OP_CZ1;
                5'd17:   op = OP_CZ2;
                5'd18:   op = OP_KP;
                5'd19:   op = OP_KCX;
                5'd20:   op = OP_KCY;
                5'd21:   op = OP_KCZ;
                5'd22:   op = OP_NOP;
                5'd23:   op = OP_OLO;
                5'd24:   op = OP_OHI;
                5'd25:   op = OP_ACC;
                default: op = OP_ACC;
            endcase
        end
        else
        begin
            case (step)
                5'd0:    op = OP_GXR;
                5'd1:    op = OP_GYR;
                5'd2:    op = OP_GZR;
                5'd3:    op = OP_FIN;
                5'd4:    op = OP_NOP;
                5'd5:    op = OP_OLO;
                5'd6:    op = OP_OHI;
                5'd7:    op = OP_ACC;
                default: op = OP_ACC;
            endcase
        end
        return op;
    endfunction

endpackage

[hdl/keda_ctrl.sv]
// Sequencer for the accumulator: walks the operation schedule, one
// operation per cycle when not stalled. Depends on keda_pkg.
module keda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  keda_pkg::keda_stat_t stat,
    output keda_pkg::keda_cmd_t  cmd
);
    import keda_pkg::*;

    keda_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    keda_op_t             sched;
    logic                 stall;

    assign sched = sched_op(stat.complex_mode, step_reg);
    // hold the final step while the previous total is still waiting
    assign stall = (sched == OP_ACC) && stat.last_vector && stat.out_full;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    if (sched == OP_ACC)
                        state_next = ST_IDLE;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.load = 1'b0;
        cmd.op   = OP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                if (!stall)
                    cmd.op = sched;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[hdl/keda_dpath.sv]
// Datapath: item and config registers, one shared signed multiplier with a
// registered product, partial sum registers and the saturating accumulator.
// Depends on keda_pkg.
module keda_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  keda_pkg::keda_cmd_t                   cmd,
    output keda_pkg::keda_stat_t                  stat,
    input  logic                                  cfg_we,
    input  logic [keda_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [keda_pkg::SAMPLE_W-1:0]         cfg_wdata,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  psi_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  psi_im,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_x_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_x_im,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_y_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_y_im,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_z_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_z_im,
    input  logic [keda_pkg::OCC_W-1:0]            occupancy,
    input  logic                                  last_vector,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [keda_pkg::ACC_W-1:0]     density_contribution,
    output logic                                  saturated
);
    import keda_pkg::*;

    // configuration
    logic                        complex_mode_reg;
    logic signed [SAMPLE_W-1:0]  k_x_reg, k_y_reg, k_z_reg;

    // captured item
    logic signed [SAMPLE_W-1:0]  pre_reg, pim_reg;
    logic signed [SAMPLE_W-1:0]  gxr_reg, gxi_reg, gyr_reg, gyi_reg, gzr_reg, gzi_reg;
    logic [OCC_W-1:0]            occ_reg;
    logic                        last_reg;

    // multiplier and write-back stage
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [P_W-1:0]       prod_next, prod_reg, prod_sh;
    keda_op_t                    wb_op_reg;

    // partial results
    logic signed [GSUM_W-1:0]    gsum_reg, gsum_next, ps_g;
    logic signed [MUL_W-1:0]     ksq_reg, ksq_next, psq_reg, psq_next, ps_m;
    logic signed [MUL_W-1:0]     crx_reg, crx_next, cry_reg, cry_next, crz_reg, crz_next;
    logic signed [TERM_W-1:0]    term_reg, term_next, ps_t, term_hi;
    logic signed [WP_W-1:0]      wprod_reg, wprod_next, wprod_sh;

    // accumulator
    logic signed [ACC_W-1:0]     acc_reg, acc_sat, dens_reg;
    logic                        clip_reg, sat_reg, out_valid_reg;
    logic signed [ACC_W:0]       acc_sum;
    logic                        acc_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complex_mode_reg <= 1'b0;
            k_x_reg          <= '0;
            k_y_reg          <= '0;
            k_z_reg          <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMPLEX_MODE: complex_mode_reg <= cfg_wdata[0];
                CFG_K_X:          k_x_reg <= $signed(cfg_wdata);
                CFG_K_Y:          k_y_reg <= $signed(cfg_wdata);
                CFG_K_Z:          k_z_reg <= $signed(cfg_wdata);
                default:          complex_mode_reg <= complex_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pre_reg  <= psi_re;
            pim_reg  <= psi_im;
            gxr_reg  <= grad_x_re;
            gxi_reg  <= grad_x_im;
            gyr_reg  <= grad_y_re;
            gyi_reg  <= grad_y_im;
            gzr_reg  <= grad_z_re;
            gzi_reg  <= grad_z_im;
            occ_reg  <= occupancy;
            last_reg <= last_vector;
        end
    end

    assign term_hi = term_reg >>> LO_W;

    // operand select for the issued operation
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_GXR:  begin mul_a = MUL_W'(gxr_reg); mul_b = MUL_W'(gxr_reg); end
            OP_GYR:  begin mul_a = MUL_W'(gyr_reg); mul_b = MUL_W'(gyr_reg); end
            OP_GZR:  begin mul_a = MUL_W'(gzr_reg); mul_b = MUL_W'(gzr_reg); end
            OP_GXI:  begin mul_a = MUL_W'(gxi_reg); mul_b = MUL_W'(gxi_reg); end
            OP_GYI:  begin mul_a = MUL_W'(gyi_reg); mul_b = MUL_W'(gyi_reg); end
            OP_GZI:  begin mul_a = MUL_W'(gzi_reg); mul_b = MUL_W'(gzi_reg); end
            OP_KX:   begin mul_a = MUL_W'(k_x_reg); mul_b = MUL_W'(k_x_reg); end
            OP_KY:   begin mul_a = MUL_W'(k_y_reg); mul_b = MUL_W'(k_y_reg); end
            OP_KZ:   begin mul_a = MUL_W'(k_z_reg); mul_b = MUL_W'(k_z_reg); end
            OP_PR:   begin mul_a = MUL_W'(pre_reg); mul_b = MUL_W'(pre_reg); end
            OP_PI:   begin mul_a = MUL_W'(pim_reg); mul_b = MUL_W'(pim_reg); end
            OP_CX1:  begin mul_a = MUL_W'(pre_reg); mul_b = MUL_W'(gxi_reg); end
            OP_CX2:  begin mul_a = MUL_W'(pim_reg); mul_b = MUL_W'(gxr_reg); end
            OP_CY1:  begin mul_a = MUL_W'(pre_reg); mul_b = MUL_W'(gyi_reg); end
            OP_CY2:  begin mul_a = MUL_W'(pim_reg); mul_b = MUL_W'(gyr_reg); end
            OP_CZ1:  begin mul_a = MUL_W'(pre_reg); mul_b = MUL_W'(gzi_reg); end
            OP_CZ2:  begin mul_a = MUL_W'(pim_reg); mul_b = MUL_W'(gzr_reg); end
            OP_KP:   begin mul_a = ksq_reg;         mul_b = psq_reg;         end
            OP_KCX:  begin mul_a = MUL_W'(k_x_reg); mul_b = crx_reg;         end
            OP_KCY:  begin mul_a = MUL_W'(k_y_reg); mul_b = cry_reg;         end
            OP_KCZ:  begin mul_a = MUL_W'(k_z_reg); mul_b = crz_reg;         end
            OP_OLO:
            begin
                mul_a = $signed({{(MUL_W-LO_W){1'b0}}, term_reg[LO_W-1:0]});
                mul_b = $signed({{(MUL_W-OCC_W){1'b0}}, occ_reg});
            end
            OP_OHI:
            begin
                mul_a = $signed(term_hi[MUL_W-1:0]);
                mul_b = $signed({{(MUL_W-OCC_W){1'b0}}, occ_reg});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_op_reg <= OP_NOP;
        else
            wb_op_reg <= cmd.op;
    end

    // floor rounding of every Q product is an arithmetic shift
    assign prod_sh = prod_reg >>> FRAC_W;
    assign ps_g    = $signed(prod_sh[GSUM_W-1:0]);
    assign ps_m    = $signed(prod_sh[MUL_W-1:0]);
    assign ps_t    = $signed(prod_sh[TERM_W-1:0]);

    always_comb
    begin
        gsum_next  = gsum_reg;
        ksq_next   = ksq_reg;
        psq_next   = psq_reg;
        crx_next   = crx_reg;
        cry_next   = cry_reg;
        crz_next   = crz_reg;
        term_next  = term_reg;
        wprod_next = wprod_reg;
        case (wb_op_reg)
            OP_GXR:  gsum_next = ps_g;
            OP_GYR,
            OP_GZR,
            OP_GXI,
            OP_GYI,
            OP_GZI:  gsum_next = gsum_reg + ps_g;
            OP_FIN:  term_next = TERM_W'(gsum_reg >>> 1);
            OP_KX:   ksq_next = ps_m;
            OP_KY,
            OP_KZ:   ksq_next = ksq_reg + ps_m;
            OP_PR:   psq_next = ps_m;
            OP_PI:   psq_next = psq_reg + ps_m;
            OP_CX1:  crx_next = ps_m;
            OP_CX2:  crx_next = crx_reg - ps_m;
            OP_CY1:  cry_next = ps_m;
            OP_CY2:  cry_next = cry_reg - ps_m;
            OP_CZ1:  crz_next = ps_m;
            OP_CZ2:  crz_next = crz_reg - ps_m;
            OP_KP,
            OP_KCX,
            OP_KCY,
            OP_KCZ:  term_next = term_reg + ps_t;
            OP_OLO:  wprod_next = WP_W'(prod_reg);
            OP_OHI:  wprod_next = wprod_reg + (WP_W'(prod_reg) <<< LO_W);
            default: gsum_next = gsum_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        gsum_reg  <= gsum_next;
        ksq_reg   <= ksq_next;
        psq_reg   <= psq_next;
        crx_reg   <= crx_next;
        cry_reg   <= cry_next;
        crz_reg   <= crz_next;
        term_reg  <= term_next;
        wprod_reg <= wprod_next;
    end

    // saturating accumulate of the weighted term
    assign wprod_sh = wprod_reg >>> FRAC_W;
    assign acc_sum  = (ACC_W+1)'(acc_reg) + $signed(wprod_sh[ACC_W:0]);
    assign acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];

    always_comb
    begin
        if (!acc_ovf)
            acc_sat = acc_sum[ACC_W-1:0];
        else if (acc_sum[ACC_W])
            acc_sat = ACC_MIN;
        else
            acc_sat = ACC_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new total only lands on an empty output register
            if (wb_op_reg == OP_ACC && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (wb_op_reg == OP_ACC)
            begin
                if (last_reg)
                begin
                    acc_reg  <= '0;
                    clip_reg <= 1'b0;
                end
                else
                begin
                    acc_reg  <= acc_sat;
                    clip_reg <= clip_reg | acc_ovf;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_op_reg == OP_ACC && last_reg)
        begin
            dens_reg <= acc_sat;
            sat_reg  <= clip_reg | acc_ovf;
        end
    end

    assign out_valid            = out_valid_reg;
    assign density_contribution = dens_reg;
    assign saturated            = sat_reg;

    assign stat.complex_mode = complex_mode_reg;
    assign stat.last_vector  = last_reg;
    assign stat.out_full     = out_valid_reg;

endmodule

[hdl/kinetic_energy_density_accumulator_top.sv]
// Kinetic energy density accumulator, top level.
// The single shared multiplier, issuing one product a cycle while not stalled,
// serves one beat at a time: a new beat is taken only once the previous
// beat's whole operation schedule has been issued.
// A last beat whose total finds the output register still full waits there.
// Reset (rst_n, async, active low) clears config, accumulator and clip flag.
module kinetic_energy_density_accumulator_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port: 0 complex_mode, 1..3 k_x, k_y, k_z
    input  logic                                  cfg_we,
    input  logic [keda_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [keda_pkg::SAMPLE_W-1:0]         cfg_wdata,
    // input channel: one beat per wavefunction vector
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  psi_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  psi_im,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_x_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_x_im,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_y_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_y_im,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_z_re,
    input  logic signed [keda_pkg::SAMPLE_W-1:0]  grad_z_im,
    input  logic [keda_pkg::OCC_W-1:0]            occupancy,
    input  logic                                  last_vector,
    // output channel: one beat per quadrature point
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [keda_pkg::ACC_W-1:0]     density_contribution,
    output logic                                  saturated
);
    import keda_pkg::*;

    // Controller issues one operation per cycle unless stalled; the
    // datapath registers each product and writes it back the next cycle.
    keda_cmd_t  cmd;
    keda_stat_t stat;

    keda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Output register decouples the sides: the next beat is taken while a
    // finished total still waits for out_ready.
    keda_dpath u_dpath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .psi_re               (psi_re),
        .psi_im               (psi_im),
        .grad_x_re            (grad_x_re),
        .grad_x_im            (grad_x_im),
        .grad_y_re            (grad_y_re),
        .grad_y_im            (grad_y_im),
        .grad_z_re            (grad_z_re),
        .grad_z_im            (grad_z_im),
        .occupancy            (occupancy),
        .last_vector          (last_vector),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .density_contribution (density_contribution),
        .saturated            (saturated)
    );

endmodule

[tb/kinetic_energy_density_accumulator_top_tb.sv]
// Self-checking testbench for kinetic_energy_density_accumulator_top.
// Holds a bit-exact fixed-point predictor of the per-point kinetic density sum.
// Needs only keda_pkg and the top-level RTL.
`timescale 1ns / 1ps

module kinetic_energy_density_accumulator_top_tb;
    import keda_pkg::*;

    // Cycles to wait after the last result before touching config or ending;
    // covers a pending complex-mode beat's schedule with margin.
    localparam int SETTLE_CYCLES = 40;
    // Run limit in ns; the clock period is 12 ns.
    localparam int RUN_LIMIT_NS  = 15_000_000;
    // Enough max-magnitude beats in one point to push the sum past 2^47;
    // the sum first clips on beat 1206.
    localparam int CLIP_VECTORS  = 1208;
    localparam int RANDOM_VECTORS = 64;

    localparam longint ACC_HI    = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO    = -ACC_HI - 1;
    localparam longint PROD_CLIP = 64'sh7FFF_FFFF_FFFF_FFFF >>> FRAC_W;

    localparam logic [SAMPLE_W-1:0] S_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] S_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] S_ONE   = SAMPLE_W'(1) << FRAC_W;
    localparam logic [SAMPLE_W-1:0] S_LSB   = SAMPLE_W'(1);
    localparam logic [SAMPLE_W-1:0] S_NLSB  = '1;
    localparam logic [OCC_W-1:0]    OCC_TWO = OCC_W'(1) << (FRAC_W + 1);
    localparam logic [OCC_W-1:0]    OCC_TOP = '1;

    // One wavefunction vector at a quadrature point
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] psi_re;
        logic signed [SAMPLE_W-1:0] psi_im;
        logic signed [SAMPLE_W-1:0] gx_re;
        logic signed [SAMPLE_W-1:0] gx_im;
        logic signed [SAMPLE_W-1:0] gy_re;
        logic signed [SAMPLE_W-1:0] gy_im;
        logic signed [SAMPLE_W-1:0] gz_re;
        logic signed [SAMPLE_W-1:0] gz_im;
        logic [OCC_W-1:0]           occ;
        logic                       last;
    } kv_vec_t;

    // What the block reports at the end of a point
    typedef struct packed {
        logic signed [ACC_W-1:0] density;
        logic                    sat;
    } point_res_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [SAMPLE_W-1:0]        cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] psi_re;
    logic signed [SAMPLE_W-1:0] psi_im;
    logic signed [SAMPLE_W-1:0] grad_x_re;
    logic signed [SAMPLE_W-1:0] grad_x_im;
    logic signed [SAMPLE_W-1:0] grad_y_re;
    logic signed [SAMPLE_W-1:0] grad_y_im;
    logic signed [SAMPLE_W-1:0] grad_z_re;
    logic signed [SAMPLE_W-1:0] grad_z_im;
    logic [OCC_W-1:0]           occupancy;
    logic                       last_vector;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [ACC_W-1:0]    density_contribution;
    logic                       saturated;

    // Predictor's private copy of config and accumulator state
    logic                       mode_q = 1'b0;
    logic signed [SAMPLE_W-1:0] kpt_q [3] = '{default: '0};
    longint                     acc_q = 0;
    bit                         clip_q = 1'b0;
    bit                         prod_clip;

    point_res_t expected_points [$];

    // Traffic shaping knobs shared between the test tasks and the BFMs
    int  burst_left = 0;
    bit  tx_steady = 1'b0;
    int  rx_hold_left = 0;

    int  fail_count = 0;
    int  vectors_sent = 0;
    int  points_checked = 0;
    int  clipped_points = 0;

    kinetic_energy_density_accumulator_top i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .psi_re               (psi_re),
        .psi_im               (psi_im),
        .grad_x_re            (grad_x_re),
        .grad_x_im            (grad_x_im),
        .grad_y_re            (grad_y_re),
        .grad_y_im            (grad_y_im),
        .grad_z_re            (grad_z_re),
        .grad_z_im            (grad_z_im),
        .occupancy            (occupancy),
        .last_vector          (last_vector),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .density_contribution (density_contribution),
        .saturated            (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Exact product, floored to FRAC_W fraction bits. A product beyond 63 bits
    // clips to the largest shifted magnitude and marks the point clipped.
    function automatic longint qmul(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        logic signed [127:0] mag;
        wa = a;
        wb = b;
        p = wa * wb;
        mag = (p < 0) ? -p : p;
        if (mag > 128'sd9223372036854775807)
        begin
            prod_clip = 1'b1;
            return ((a < 0) != (b < 0)) ? -PROD_CLIP : PROD_CLIP;
        end
        p = p >>> FRAC_W;
        return p[63:0];
    endfunction

    // Folds one vector into the running sum; returns 1 with the point's
    // total when the vector closes the point.
    function automatic bit kinetic_density(input kv_vec_t v, output point_res_t r);
        longint p_re;
        longint p_im;
        longint occ;
        longint gsum;
        longint term;
        longint weighted;
        longint ksq;
        longint psq;
        longint cr_term;
        longint g_re [3];
        longint g_im [3];
        longint kk [3];
        r = '0;
        prod_clip = 1'b0;
        p_re = $signed(v.psi_re);
        p_im = $signed(v.psi_im);
        g_re[0] = $signed(v.gx_re);
        g_im[0] = $signed(v.gx_im);
        g_re[1] = $signed(v.gy_re);
        g_im[1] = $signed(v.gy_im);
        g_re[2] = $signed(v.gz_re);
        g_im[2] = $signed(v.gz_im);
        for (int d = 0; d < 3; d++)
            kk[d] = kpt_q[d];
        occ = v.occ;

        // 0.5*|grad psi|^2, halving drops the low bit
        gsum = 0;
        for (int d = 0; d < 3; d++)
        begin
            gsum += qmul(g_re[d], g_re[d]);
            if (mode_q)
                gsum += qmul(g_im[d], g_im[d]);
        end
        term = gsum >>> 1;

        // k-point terms: |k|^2*|psi|^2 plus k . (Re psi Im g - Im psi Re g)
        if (mode_q)
        begin
            ksq = 0;
            for (int d = 0; d < 3; d++)
                ksq += qmul(kk[d], kk[d]);
            psq = qmul(p_re, p_re) + qmul(p_im, p_im);
            term += qmul(ksq, psq);
            for (int d = 0; d < 3; d++)
            begin
                cr_term = qmul(p_re, g_im[d]) - qmul(p_im, g_re[d]);
                term += qmul(kk[d], cr_term);
            end
        end

        weighted = qmul(term, occ);
        if (prod_clip)
            clip_q = 1'b1;

        // saturating accumulate
        if (weighted > 0 && acc_q > ACC_HI - weighted)
        begin
            acc_q = ACC_HI;
            clip_q = 1'b1;
        end
        else if (weighted < 0 && acc_q < ACC_LO - weighted)
        begin
            acc_q = ACC_LO;
            clip_q = 1'b1;
        end
        else
            acc_q += weighted;

        if (!v.last)
            return 1'b0;
        r.density = acc_q[ACC_W-1:0];
        r.sat = clip_q;
        acc_q = 0;
        clip_q = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Biased toward the corners: full-scale, zero, +-1 LSB, then anything
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return S_LSB;
            4: return S_NLSB;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Mostly the physical 0..2.0 range, with some beats above 2.0
    function automatic logic [OCC_W-1:0] rand_occ();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return OCC_TWO;
            2: return OCC_TOP;
            3: return OCC_W'($urandom());
            default: return OCC_W'($urandom_range(0, 2097152));
        endcase
    endfunction

    function automatic kv_vec_t rand_vec(input bit last);
        kv_vec_t v;
        v.psi_re = rand_sample();
        v.psi_im = rand_sample();
        v.gx_re = rand_sample();
        v.gx_im = rand_sample();
        v.gy_re = rand_sample();
        v.gy_im = rand_sample();
        v.gz_re = rand_sample();
        v.gz_im = rand_sample();
        v.occ = rand_occ();
        v.last = last;
        return v;
    endfunction

    // Same gradient along x, y and z; good enough for corner beats
    function automatic kv_vec_t make_vec(input logic [SAMPLE_W-1:0] p_re,
                                         input logic [SAMPLE_W-1:0] p_im,
                                         input logic [SAMPLE_W-1:0] g_re,
                                         input logic [SAMPLE_W-1:0] g_im,
                                         input logic [OCC_W-1:0] occ,
                                         input bit last);
        kv_vec_t v;
        v.psi_re = p_re;
        v.psi_im = p_im;
        v.gx_re = g_re;
        v.gx_im = g_im;
        v.gy_re = g_re;
        v.gy_im = g_im;
        v.gz_re = g_re;
        v.gz_im = g_im;
        v.occ = occ;
        v.last = last;
        return v;
    endfunction

    // Input BFM: offers one beat, honoring the burst/gap pattern, and
    // books the expected total when the beat closes a point.
    task automatic send_vector(input kv_vec_t v);
        int gap;
        point_res_t r;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!tx_steady)
                gap = $urandom_range(1, 14);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        psi_re <= v.psi_re;
        psi_im <= v.psi_im;
        grad_x_re <= v.gx_re;
        grad_x_im <= v.gx_im;
        grad_y_re <= v.gy_re;
        grad_y_im <= v.gy_im;
        grad_z_re <= v.gz_re;
        grad_z_im <= v.gz_im;
        occupancy <= v.occ;
        last_vector <= v.last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        vectors_sent++;
        if (kinetic_density(v, r))
            expected_points.push_back(r);
    endtask

    task automatic send_random_point(input int len);
        for (int i = 0; i < len; i++)
            send_vector(rand_vec(i == len - 1));
    endtask

    // Idle the input and wait for every booked total, then let the
    // pipeline empty of beats that close no point.
    task automatic drain_points();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_COMPLEX_MODE: mode_q = data[0];
            CFG_K_X:          kpt_q[0] = data;
            CFG_K_Y:          kpt_q[1] = data;
            CFG_K_Z:          kpt_q[2] = data;
            default:          ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Full reconfiguration, only ever done on an idle block. The mode write
    // carries junk in the upper bits, which must be ignored.
    task automatic load_config(input logic mode,
                               input logic [SAMPLE_W-1:0] kx,
                               input logic [SAMPLE_W-1:0] ky,
                               input logic [SAMPLE_W-1:0] kz);
        drain_points();
        write_reg(CFG_COMPLEX_MODE, SAMPLE_W'({$urandom(), mode}));
        write_reg(CFG_K_X, kx);
        write_reg(CFG_K_Y, ky);
        write_reg(CFG_K_Z, kz);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Real mode with a nonzero k loaded: imaginary parts and k must not
    // leak in. Covers full-scale fields, zero occupancy and occupancy > 2.0.
    task automatic test_real_mode();
        load_config(1'b0, S_MAX, S_MIN, SAMPLE_W'($urandom()));
        send_vector(make_vec(S_MAX, S_MAX, S_MAX, S_MAX, OCC_TWO, 1'b1));
        send_vector(make_vec(S_MIN, S_MIN, S_MIN, S_MIN, OCC_TOP, 1'b0));
        send_vector(make_vec(S_MIN, S_MAX, S_MIN, S_MAX, OCC_TOP, 1'b1));
        send_vector(make_vec('0, S_MAX, '0, S_MIN, OCC_TWO, 1'b1));
        send_vector(make_vec(S_MAX, S_MIN, S_MAX, S_MIN, '0, 1'b1));
        send_vector(make_vec(S_LSB, S_NLSB, S_NLSB, S_LSB, S_LSB, 1'b1));
    endtask

    // Complex mode at the k corners, k = 0, and a tiny case where floor
    // rounding of the cross term drives the total negative.
    task automatic test_complex_mode();
        load_config(1'b1, S_MAX, S_MAX, S_MAX);
        send_vector(make_vec(S_MAX, S_MAX, S_MAX, S_MAX, OCC_TWO, 1'b0));
        send_vector(make_vec(S_MIN, S_MAX, S_MIN, S_MAX, OCC_TOP, 1'b1));
        send_vector(make_vec(S_MAX, S_MIN, S_MIN, S_MAX, OCC_TWO, 1'b0));
        send_vector(make_vec(S_NLSB, S_LSB, S_MAX, S_MIN, OCC_TOP, 1'b1));

        load_config(1'b1, S_MIN, S_MIN, S_MIN);
        send_vector(make_vec(S_MIN, S_MIN, S_MIN, S_MAX, OCC_TOP, 1'b1));
        send_vector(make_vec(S_MAX, S_MAX, S_MAX, S_MIN, OCC_TWO, 1'b0));
        send_vector(make_vec('0, '0, '0, '0, OCC_TOP, 1'b0));
        send_vector(make_vec(S_MIN, S_MAX, '0, S_MIN, '0, 1'b1));

        load_config(1'b1, '0, '0, '0);
        send_vector(make_vec(S_MAX, S_MIN, S_MAX, S_MIN, OCC_TWO, 1'b0));
        send_vector(make_vec(S_MIN, S_MAX, S_MIN, S_MAX, OCC_TOP, 1'b1));

        // k = (1.0, 0, 0), psi = 1 LSB, Im grad = -1 LSB: term floors to -1
        load_config(1'b1, S_ONE, '0, '0);
        send_vector(make_vec(S_LSB, '0, '0, S_NLSB, OCC_TWO, 1'b1));
        send_vector(make_vec(S_ONE, S_NLSB, S_LSB, S_NLSB, OCC_TOP, 1'b1));
    endtask

    // One very long point of full-scale beats: the running sum must clip
    // at the top of the accumulator range and flag the point. The next
    // point must start clean.
    task automatic test_accumulator_clip();
        load_config(1'b1, S_MIN, S_MIN, S_MIN);
        tx_steady = 1'b1;
        for (int i = 0; i < CLIP_VECTORS; i++)
            send_vector(make_vec(S_MIN, S_MIN, S_MIN, S_MAX, OCC_TOP,
                                 i == CLIP_VECTORS - 1));
        tx_steady = 1'b0;
        send_random_point(3);
    endtask

    // Receiver holds off for a long stretch while the sender streams
    // one-beat points back to back: the output register fills and the
    // input must stall. Then the sender waits for everything to come out.
    task automatic test_output_backpressure();
        load_config(1'b0, rand_sample(), rand_sample(), rand_sample());
        tx_steady = 1'b1;
        rx_hold_left = 400;
        repeat (16) send_vector(rand_vec(1'b1));
        tx_steady = 1'b0;
        drain_points();
    endtask

    // Random points over several configurations: mostly short points,
    // some long ones, with the k extremes among the settings.
    task automatic test_random_points(input int total);
        int phase_items;
        int len;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       load_config(1'b0, rand_sample(), rand_sample(), rand_sample());
                1:       load_config(1'b1, S_MAX, S_MAX, S_MAX);
                2:       load_config(1'b1, S_MIN, S_MIN, S_MIN);
                3:       load_config(1'b1, '0, '0, '0);
                default: load_config(1'($urandom_range(0, 1)), rand_sample(),
                                     rand_sample(), rand_sample());
            endcase
            tx_steady = (p % 3 == 1);
            phase_items = 0;
            while (phase_items < total / 8)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(10, 20);
                else
                    len = $urandom_range(1, 5);
                send_random_point(len);
                phase_items += len;
            end
        end
        tx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and result checking
    // ------------------------------------------------------------------

    // Rotating 32-bit ready pattern, reloaded whenever its tick counter runs
    // out; one reload in four is all ones so there are stretches with no
    // stalls at all. A requested hold-off overrides the pattern.
    initial
    begin
        logic [31:0] rx_pattern;
        int          rx_tick;
        rx_pattern = '1;
        rx_tick = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                if (rx_tick == 0)
                begin
                    rx_tick = 48;
                    rx_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom();
                end
                rx_tick--;
                out_ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
            end
        end
    end

    // Every accepted result beat is matched against the oldest booked total
    initial
    begin
        point_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: result with none expected: density=%0d saturated=%0b",
                             $time, density_contribution, saturated);
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (density_contribution !== want.density)
                    begin
                        $display("%0t: density_contribution expected %0d actual %0d",
                                 $time, want.density, density_contribution);
                        fail_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.sat, saturated);
                        fail_count++;
                    end
                    points_checked++;
                    if (want.sat)
                        clipped_points++;
                end
            end
        end
    end

    // Hard stop if the handshakes ever hang
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still outstanding", $time,
                 expected_points.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        psi_re <= '0;
        psi_im <= '0;
        grad_x_re <= '0;
        grad_x_im <= '0;
        grad_y_re <= '0;
        grad_y_im <= '0;
        grad_z_re <= '0;
        grad_z_im <= '0;
        occupancy <= '0;
        last_vector <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_real_mode();
        test_complex_mode();
        test_accumulator_clip();
        test_output_backpressure();
        test_random_points(RANDOM_VECTORS);
        drain_points();

        $display("Ran %0d vectors into %0d checked points (%0d clipped) over real and complex",
                 vectors_sent, points_checked, clipped_points);
        $display("modes, k corners, occupancy above 2.0, long output hold-off and saturation.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hdl/keda_pkg.sv
hdl/keda_ctrl.sv
hdl/keda_dpath.sv
hdl/kinetic_energy_density_accumulator_top.sv
tb/kinetic_energy_density_accumulator_top_tb.sv
